[rtl/gwer_pkg.sv]
// ----------------------------------------------------------------------------
// gwer_pkg: shared types and constants for the grid-to-earth wind rotation
// Formats, turn constants, the arctangent table and the words passed
// between the pipeline sections.
// ----------------------------------------------------------------------------
package gwer_pkg;

   // Default number of CORDIC cells and the size of the arctangent table.
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_ENTRIES = 24;

   // Field and internal widths.
   localparam int WIND_W = 16;
   localparam int LON_W = 17;
   localparam int CONE_W = 16;
   localparam int D_W = 18;
   localparam int PROD_W = D_W + CONE_W + 1;
   localparam int PHI_W = 31;
   localparam int GUARD_BITS = 14;
   localparam int XY_W = 33;
   localparam int GAIN_W = 31;
   localparam int MUL_W = XY_W + GAIN_W;
   localparam int RND_SHIFT = 30 + GUARD_BITS;

   // Longitude wrap, in 1/128 degree.
   localparam int WRAP_LIMIT = 23040;
   localparam int WRAP_SPAN = 46080;

   // Angle constants in 2^-22 degree.
   localparam longint FULL_TURN = 64'sd1509949440;
   localparam longint HALF_TURN = 64'sd754974720;
   localparam longint QUARTER_TURN = 64'sd377487360;

   // Inverse CORDIC gain, scaled by 2^30.
   localparam logic signed [GAIN_W-1:0] INV_GAIN = 31'sd652032874;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_LONGITUDE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONE_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGGERED_MODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_CHECK_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_CODE = 3'd4;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [WIND_W-1:0] center_longitude;
      logic [CONE_W-1:0] cone_factor;
      logic staggered_mode;
      logic missing_check_enable;
      logic signed [WIND_W-1:0] missing_code;
   } cfg_type;

   // Word leaving the front end: winds, averaged in staggered mode, and the raw angle product.
   typedef struct packed {
      logic valid;
      logic missing;
      logic signed [WIND_W-1:0] uk;
      logic signed [WIND_W-1:0] vk;
      logic signed [PROD_W-1:0] phi_raw;
   } prod_type;

   // Word moving along the CORDIC cell chain.
   typedef struct packed {
      logic valid;
      logic missing;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [PHI_W-1:0] phi;
   } lane_type;

   // atan(2^-i) in 2^-22 degree, rounded to nearest.
   function automatic logic signed [PHI_W-1:0] atan_step(input int i);
      logic signed [PHI_W-1:0] a;
      case (i)
         0: a = 31'sd188743680;
         1: a = 31'sd111421900;
         2: a = 31'sd58872272;
         3: a = 31'sd29884485;
         4: a = 31'sd15000234;
         5: a = 31'sd7507429;
         6: a = 31'sd3754631;
         7: a = 31'sd1877430;
         8: a = 31'sd938729;
         9: a = 31'sd469366;
         10: a = 31'sd234683;
         11: a = 31'sd117342;
         12: a = 31'sd58671;
         13: a = 31'sd29335;
         14: a = 31'sd14668;
         15: a = 31'sd7334;
         16: a = 31'sd3667;
         17: a = 31'sd1833;
         18: a = 31'sd917;
         19: a = 31'sd458;
         20: a = 31'sd229;
         21: a = 31'sd115;
         22: a = 31'sd57;
         23: a = 31'sd29;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[rtl/gwer_prep.sv]
// ----------------------------------------------------------------------------
// gwer_prep: front end of the wind rotation pipeline
// Missing-value test, neighbour averaging, longitude offset with wrap,
// then the angle product of offset and cone factor.
// ----------------------------------------------------------------------------
module gwer_prep (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  gwer_pkg::cfg_type cfg,
   input  logic req_valid,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_u_here,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_u_east,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_v_here,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_v_north,
   input  logic signed [gwer_pkg::LON_W-1:0] req_longitude,
   output gwer_pkg::prod_type prod_out
);

   localparam int W = gwer_pkg::WIND_W;
   localparam int DW = gwer_pkg::D_W;

   logic s1_valid_ff;
   logic s1_miss_ff, s1_miss_in;
   logic signed [W-1:0] s1_uk_ff, s1_uk_in;
   logic signed [W-1:0] s1_vk_ff, s1_vk_in;
   logic signed [DW-1:0] s1_d_ff, s1_d_in;
   logic signed [W:0] u_sum, v_sum;
   logic signed [DW-1:0] d_raw;
   logic signed [gwer_pkg::CONE_W:0] cone_s;
   gwer_pkg::prod_type prod_ff, prod_in;

   // Stage one: missing test, averaging and wrapped longitude offset.
   always_comb begin
      u_sum = {req_u_here[W-1], req_u_here} + {req_u_east[W-1], req_u_east};
      v_sum = {req_v_here[W-1], req_v_here} + {req_v_north[W-1], req_v_north};
      s1_miss_in = cfg.missing_check_enable &&
         ((req_u_here == cfg.missing_code) || (req_v_here == cfg.missing_code) ||
          (cfg.staggered_mode &&
           ((req_u_east == cfg.missing_code) || (req_v_north == cfg.missing_code))));
      if (cfg.staggered_mode) begin
         s1_uk_in = u_sum[W:1];
         s1_vk_in = v_sum[W:1];
      end else begin
         s1_uk_in = req_u_here;
         s1_vk_in = req_v_here;
      end
      d_raw = {req_longitude[gwer_pkg::LON_W-1], req_longitude}
            - {{(DW-W){cfg.center_longitude[W-1]}}, cfg.center_longitude};
      if (d_raw > gwer_pkg::WRAP_LIMIT) begin
         s1_d_in = DW'(d_raw - gwer_pkg::WRAP_SPAN);
      end else if (d_raw < -gwer_pkg::WRAP_LIMIT) begin
         s1_d_in = DW'(d_raw + gwer_pkg::WRAP_SPAN);
      end else begin
         s1_d_in = d_raw;
      end
   end

   // Stage two: angle product in 2^-22 degree.
   always_comb begin
      cone_s = {1'b0, cfg.cone_factor};
      prod_in.valid = s1_valid_ff;
      prod_in.missing = s1_miss_ff;
      prod_in.uk = s1_uk_ff;
      prod_in.vk = s1_vk_ff;
      prod_in.phi_raw = s1_d_ff * cone_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prod_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         prod_ff.valid <= prod_in.valid;
      end
      if (adv) begin
         s1_miss_ff <= s1_miss_in;
         s1_uk_ff <= s1_uk_in;
         s1_vk_ff <= s1_vk_in;
         s1_d_ff <= s1_d_in;
         prod_ff.missing <= prod_in.missing;
         prod_ff.uk <= prod_in.uk;
         prod_ff.vk <= prod_in.vk;
         prod_ff.phi_raw <= prod_in.phi_raw;
      end
   end

   assign prod_out = prod_ff;

endmodule

[rtl/gwer_angle.sv]
// ----------------------------------------------------------------------------
// gwer_angle: angle reduction ahead of the CORDIC chain
// Brings the angle into one half turn either side of zero, then applies an
// exact quarter turn so the chain sees at most ninety degrees.
// ----------------------------------------------------------------------------
module gwer_angle (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  gwer_pkg::prod_type prod_in,
   output gwer_pkg::lane_type lane_out
);

   localparam int PW = gwer_pkg::PROD_W;
   localparam int FW = gwer_pkg::PHI_W;
   localparam int XW = gwer_pkg::XY_W;
   localparam int W = gwer_pkg::WIND_W;
   localparam int G = gwer_pkg::GUARD_BITS;

   logic r_valid_ff;
   logic r_miss_ff;
   logic signed [W-1:0] r_uk_ff, r_vk_ff;
   logic signed [FW-1:0] r_phi_ff, r_phi_in;
   logic signed [PW-1:0] turn_ofs, phi_mod;
   logic signed [XW-1:0] xs, ys;
   gwer_pkg::lane_type lane_ff, lane_in;

   // Stage three: subtract the whole turns that the magnitude calls for.
   always_comb begin
      if (prod_in.phi_raw > gwer_pkg::HALF_TURN + gwer_pkg::FULL_TURN) begin
         turn_ofs = PW'(2 * gwer_pkg::FULL_TURN);
      end else if (prod_in.phi_raw > gwer_pkg::HALF_TURN) begin
         turn_ofs = PW'(gwer_pkg::FULL_TURN);
      end else if (prod_in.phi_raw <= -gwer_pkg::HALF_TURN - gwer_pkg::FULL_TURN) begin
         turn_ofs = PW'(-2 * gwer_pkg::FULL_TURN);
      end else if (prod_in.phi_raw <= -gwer_pkg::HALF_TURN) begin
         turn_ofs = PW'(-gwer_pkg::FULL_TURN);
      end else begin
         turn_ofs = '0;
      end
      phi_mod = prod_in.phi_raw - turn_ofs;
      r_phi_in = phi_mod[FW-1:0];
   end

   // Stage four: widen the winds and fold the angle into one quadrant.
   always_comb begin
      xs = {{(XW-W-G){r_uk_ff[W-1]}}, r_uk_ff, {G{1'b0}}};
      ys = {{(XW-W-G){r_vk_ff[W-1]}}, r_vk_ff, {G{1'b0}}};
      lane_in.valid = r_valid_ff;
      lane_in.missing = r_miss_ff;
      if (r_phi_ff > gwer_pkg::QUARTER_TURN) begin
         lane_in.x = -ys;
         lane_in.y = xs;
         lane_in.phi = FW'(r_phi_ff - gwer_pkg::QUARTER_TURN);
      end else if (r_phi_ff < -gwer_pkg::QUARTER_TURN) begin
         lane_in.x = ys;
         lane_in.y = -xs;
         lane_in.phi = FW'(r_phi_ff + gwer_pkg::QUARTER_TURN);
      end else begin
         lane_in.x = xs;
         lane_in.y = ys;
         lane_in.phi = r_phi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         lane_ff.valid <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= prod_in.valid;
         lane_ff.valid <= lane_in.valid;
      end
      if (adv) begin
         r_miss_ff <= prod_in.missing;
         r_uk_ff <= prod_in.uk;
         r_vk_ff <= prod_in.vk;
         r_phi_ff <= r_phi_in;
         lane_ff.missing <= lane_in.missing;
         lane_ff.x <= lane_in.x;
         lane_ff.y <= lane_in.y;
         lane_ff.phi <= lane_in.phi;
      end
   end

   assign lane_out = lane_ff;

endmodule

[rtl/gwer_cordic_cell.sv]
// ----------------------------------------------------------------------------
// gwer_cordic_cell: one micro-rotation of the CORDIC chain
// Turns the vector by plus or minus atan(2^-STEP) toward zero residual angle
// and hands the word to the next cell.
// ----------------------------------------------------------------------------
module gwer_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  gwer_pkg::lane_type lane_in,
   output gwer_pkg::lane_type lane_out
);

   localparam logic signed [gwer_pkg::PHI_W-1:0] ATAN_C = gwer_pkg::atan_step(STEP);

   logic signed [gwer_pkg::XY_W-1:0] dx, dy;
   gwer_pkg::lane_type lane_ff, cell_in;

   // Shift-and-add step; the sign of the residual picks the direction.
   always_comb begin
      dx = lane_in.y >>> STEP;
      dy = lane_in.x >>> STEP;
      cell_in = lane_in;
      if (lane_in.phi >= 0) begin
         cell_in.x = lane_in.x - dx;
         cell_in.y = lane_in.y + dy;
         cell_in.phi = lane_in.phi - ATAN_C;
      end else begin
         cell_in.x = lane_in.x + dx;
         cell_in.y = lane_in.y - dy;
         cell_in.phi = lane_in.phi + ATAN_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (adv) begin
         lane_ff.valid <= cell_in.valid;
      end
      if (adv) begin
         lane_ff.missing <= cell_in.missing;
         lane_ff.x <= cell_in.x;
         lane_ff.y <= cell_in.y;
         lane_ff.phi <= cell_in.phi;
      end
   end

   assign lane_out = lane_ff;

endmodule

[rtl/gwer_finish.sv]
// ----------------------------------------------------------------------------
// gwer_finish: gain correction and output register
// Multiplies by the inverse CORDIC gain, rounds half up to Q8.8, saturates
// and substitutes the missing code where the point was flagged.
// ----------------------------------------------------------------------------
module gwer_finish (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  gwer_pkg::lane_type lane_in,
   input  logic signed [gwer_pkg::WIND_W-1:0] missing_code,
   output logic rsp_valid,
   output logic signed [gwer_pkg::WIND_W-1:0] rsp_u_earth,
   output logic signed [gwer_pkg::WIND_W-1:0] rsp_v_earth,
   output logic rsp_is_missing
);

   localparam int MW = gwer_pkg::MUL_W;
   localparam int RS = gwer_pkg::RND_SHIFT;
   localparam int W = gwer_pkg::WIND_W;
   localparam int QW = MW - RS;
   localparam logic signed [MW-1:0] RND_HALF = MW'(64'sd1 <<< (RS - 1));

   logic m_valid_ff;
   logic m_miss_ff;
   logic signed [MW-1:0] m_px_ff, m_px_in;
   logic signed [MW-1:0] m_py_ff, m_py_in;
   logic signed [MW-1:0] rx, ry;
   logic signed [QW-1:0] qx, qy;
   logic signed [W-1:0] u_in, v_in;
   logic valid_ff;
   logic signed [W-1:0] u_ff, v_ff;
   logic miss_ff;

   // Saturate a rounded value to the 16-bit wind range.
   function automatic logic signed [W-1:0] sat_wind(input logic signed [QW-1:0] q);
      logic signed [W-1:0] s;
      if (q > QW'(32767)) begin
         s = 16'sh7FFF;
      end else if (q < -QW'(32768)) begin
         s = 16'sh8000;
      end else begin
         s = q[W-1:0];
      end
      return s;
   endfunction

   // Gain correction products.
   always_comb begin
      m_px_in = lane_in.x * gwer_pkg::INV_GAIN;
      m_py_in = lane_in.y * gwer_pkg::INV_GAIN;
   end

   // Round half up, saturate, and apply the missing code.
   always_comb begin
      rx = m_px_ff + RND_HALF;
      ry = m_py_ff + RND_HALF;
      qx = rx[MW-1:RS];
      qy = ry[MW-1:RS];
      if (m_miss_ff) begin
         u_in = missing_code;
         v_in = missing_code;
      end else begin
         u_in = sat_wind(qx);
         v_in = sat_wind(qy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= lane_in.valid;
         valid_ff <= m_valid_ff;
      end
      if (adv) begin
         m_miss_ff <= lane_in.missing;
         m_px_ff <= m_px_in;
         m_py_ff <= m_py_in;
         u_ff <= u_in;
         v_ff <= v_in;
         miss_ff <= m_miss_ff;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_u_earth = u_ff;
   assign rsp_v_earth = v_ff;
   assign rsp_is_missing = miss_ff;

endmodule

[rtl/grid_wind_to_earth_rotation.sv]
// ----------------------------------------------------------------------------
// grid_wind_to_earth_rotation: grid-relative to earth-relative wind rotation
// Streams grid points through CORDIC cells, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// One grid point is taken per clock and one result word leaves per clock
// while the result side keeps taking them. The pipeline is built from two
// front-end stages (missing test, averaging and longitude wrap; angle
// product), two angle reduction stages, one cell per CORDIC step, a gain
// multiply stage and the output register. The whole pipeline
// holds when a result waits untaken; no stage moves, empty slots included,
// and the input side is held off until the output register is taken.
// Configuration writes are always ready and should be made while no point
// is in flight.
module grid_wind_to_earth_rotation #(
   parameter int CORDIC_STEPS = gwer_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_u_here,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_u_east,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_v_here,
   input  logic signed [gwer_pkg::WIND_W-1:0] req_v_north,
   input  logic signed [gwer_pkg::LON_W-1:0] req_longitude,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [gwer_pkg::WIND_W-1:0] rsp_u_earth,
   output logic signed [gwer_pkg::WIND_W-1:0] rsp_v_earth,
   output logic rsp_is_missing,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [gwer_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gwer_pkg::WIND_W-1:0] csr_data
);

   gwer_pkg::cfg_type cfg_ff;
   gwer_pkg::prod_type prod;
   gwer_pkg::lane_type lanes [0:CORDIC_STEPS];
   logic adv;

   // The pipeline moves whenever the output register is empty or being taken.
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_longitude <= '0;
         cfg_ff.cone_factor <= '0;
         cfg_ff.staggered_mode <= 1'b0;
         cfg_ff.missing_check_enable <= 1'b0;
         cfg_ff.missing_code <= 16'sh8000;
      end else if (csr_valid) begin
         unique case (csr_index)
            gwer_pkg::CSR_CENTER_LONGITUDE: cfg_ff.center_longitude <= csr_data;
            gwer_pkg::CSR_CONE_FACTOR: cfg_ff.cone_factor <= csr_data;
            gwer_pkg::CSR_STAGGERED_MODE: cfg_ff.staggered_mode <= csr_data[0];
            gwer_pkg::CSR_MISSING_CHECK_ENABLE: cfg_ff.missing_check_enable <= csr_data[0];
            gwer_pkg::CSR_MISSING_CODE: cfg_ff.missing_code <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Front end and angle reduction.
   gwer_prep u_prep (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_u_here(req_u_here),
      .req_u_east(req_u_east),
      .req_v_here(req_v_here),
      .req_v_north(req_v_north),
      .req_longitude(req_longitude),
      .prod_out(prod)
   );

   gwer_angle u_angle (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .prod_in(prod),
      .lane_out(lanes[0])
   );

   // CORDIC cell chain, one micro-rotation per cell.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      gwer_cordic_cell #(
         .STEP(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .lane_in(lanes[i]),
         .lane_out(lanes[i+1])
      );
   end

   // Gain correction and output register.
   gwer_finish u_finish (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .lane_in(lanes[CORDIC_STEPS]),
      .missing_code(cfg_ff.missing_code),
      .rsp_valid(rsp_valid),
      .rsp_u_earth(rsp_u_earth),
      .rsp_v_earth(rsp_v_earth),
      .rsp_is_missing(rsp_is_missing)
   );

   // A flagged point carries the missing code on both winds.
   a_missing_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_missing) |->
         (rsp_u_earth == cfg_ff.missing_code) && (rsp_v_earth == cfg_ff.missing_code))
      else $error("missing flag without missing code on outputs");

   // A waiting result holds the whole pipeline, including the input side.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while result waits");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_wind_to_earth_rotation
// Streams grid points through the rotation block under random source gaps
// and result stalls. A behavioral predictor in this file computes the
// earth-relative winds of every accepted word, and each result word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STEPS = gwer_pkg::CORDIC_STEPS_DEFAULT;
   localparam int LATENCY = STEPS + 6;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 8;
   localparam int POINTS_PER_PHASE = 210;

   // Angle arithmetic in units of 2^-22 degree.
   localparam longint TURN_FULL = 64'sd1509949440;
   localparam longint TURN_HALF = 64'sd754974720;
   localparam longint TURN_QUARTER = 64'sd377487360;
   localparam longint LON_WRAP = 23040;
   localparam longint LON_SPAN = 46080;
   localparam int GUARD_SHIFT = 14;
   localparam longint GAIN_RECIP = 64'sd652032874;

   typedef struct packed {
      logic signed [gwer_pkg::WIND_W-1:0] u_here;
      logic signed [gwer_pkg::WIND_W-1:0] u_east;
      logic signed [gwer_pkg::WIND_W-1:0] v_here;
      logic signed [gwer_pkg::WIND_W-1:0] v_north;
      logic signed [gwer_pkg::LON_W-1:0] longitude;
   } grid_point_type;

   typedef struct packed {
      logic signed [gwer_pkg::WIND_W-1:0] u_earth;
      logic signed [gwer_pkg::WIND_W-1:0] v_earth;
      logic is_missing;
   } earth_wind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [gwer_pkg::WIND_W-1:0] req_u_here = '0;
   logic signed [gwer_pkg::WIND_W-1:0] req_u_east = '0;
   logic signed [gwer_pkg::WIND_W-1:0] req_v_here = '0;
   logic signed [gwer_pkg::WIND_W-1:0] req_v_north = '0;
   logic signed [gwer_pkg::LON_W-1:0] req_longitude = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [gwer_pkg::WIND_W-1:0] rsp_u_earth;
   logic signed [gwer_pkg::WIND_W-1:0] rsp_v_earth;
   logic rsp_is_missing;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gwer_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gwer_pkg::WIND_W-1:0] csr_data = '0;

   // Register copy used by the predictor, at reset values.
   logic signed [gwer_pkg::WIND_W-1:0] cfg_center = '0;
   logic [gwer_pkg::WIND_W-1:0] cfg_cone = '0;
   logic cfg_staggered = 1'b0;
   logic cfg_missing_check = 1'b0;
   logic signed [gwer_pkg::WIND_W-1:0] cfg_missing_code = 16'h8000;

   earth_wind_type expected_winds[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_burst = 0;
   int stall_left = 0;
   int free_left = 0;

   // atan(2^-i) in 2^-22 degree.
   longint atan_lut [0:23] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29
   };

   grid_wind_to_earth_rotation #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_u_here(req_u_here),
      .req_u_east(req_u_east),
      .req_v_here(req_v_here),
      .req_v_north(req_v_north),
      .req_longitude(req_longitude),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_u_earth(rsp_u_earth),
      .rsp_v_earth(rsp_v_earth),
      .rsp_is_missing(rsp_is_missing),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Undo the CORDIC gain, round half up to Q8.8 and saturate.
   function automatic logic signed [gwer_pkg::WIND_W-1:0] finish_axis(input longint v);
      longint p;
      p = v * GAIN_RECIP + (64'sd1 <<< (29 + GUARD_SHIFT));
      p = p >>> (30 + GUARD_SHIFT);
      if (p > 32767) p = 32767;
      else if (p < -32768) p = -32768;
      return p[gwer_pkg::WIND_W-1:0];
   endfunction

   // Earth-relative wind of one grid point under the current registers.
   function automatic earth_wind_type rotate_to_earth(input grid_point_type p);
      earth_wind_type r;
      longint uh, ue, vh, vn, code, cone, uk, vk, d, phi, x, y, t, dx, dy;
      bit miss;
      uh = longint'(p.u_here);
      ue = longint'(p.u_east);
      vh = longint'(p.v_here);
      vn = longint'(p.v_north);
      code = longint'(cfg_missing_code);
      cone = longint'(cfg_cone);
      miss = 1'b0;
      if (cfg_missing_check) begin
         miss = (uh == code) || (vh == code);
         if (cfg_staggered) miss = miss || (ue == code) || (vn == code);
      end
      if (miss) begin
         r.u_earth = cfg_missing_code;
         r.v_earth = cfg_missing_code;
         r.is_missing = 1'b1;
         return r;
      end
      if (cfg_staggered) begin
         uk = (uh + ue) >>> 1;
         vk = (vh + vn) >>> 1;
      end else begin
         uk = uh;
         vk = vh;
      end
      // Longitude offset, wrapped a single time.
      d = longint'(p.longitude);
      d = d - longint'(cfg_center);
      if (d > LON_WRAP) d -= LON_SPAN;
      else if (d < -LON_WRAP) d += LON_SPAN;
      // Angle into (-180, 180], then a quarter turn if beyond 90 degrees.
      phi = (d * cone) % TURN_FULL;
      if (phi < 0) phi += TURN_FULL;
      if (phi > TURN_HALF) phi -= TURN_FULL;
      x = uk <<< GUARD_SHIFT;
      y = vk <<< GUARD_SHIFT;
      if (phi > TURN_QUARTER) begin
         t = x;
         x = -y;
         y = t;
         phi -= TURN_QUARTER;
      end else if (phi < -TURN_QUARTER) begin
         t = x;
         x = y;
         y = -t;
         phi += TURN_QUARTER;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (phi >= 0) begin
            x -= dx;
            y += dy;
            phi -= atan_lut[i];
         end else begin
            x += dx;
            y -= dy;
            phi += atan_lut[i];
         end
      end
      r.u_earth = finish_axis(x);
      r.v_earth = finish_axis(y);
      r.is_missing = 1'b0;
      return r;
   endfunction

   function automatic grid_point_type make_point(input int uh, input int ue, input int vh,
                                                 input int vn, input int lon);
      grid_point_type p;
      p.u_here = 16'(uh);
      p.u_east = 16'(ue);
      p.v_here = 16'(vh);
      p.v_north = 16'(vn);
      p.longitude = 17'(lon);
      return p;
   endfunction

   // Wind values biased toward extremes, small magnitudes and the missing code.
   function automatic logic signed [gwer_pkg::WIND_W-1:0] random_wind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return cfg_missing_code;
      if (roll < 11) return 16'h7FFF;
      if (roll < 16) return 16'h8000;
      if (roll < 46) return 16'(int'($urandom_range(4096)) - 2048);
      return 16'($urandom());
   endfunction

   function automatic grid_point_type random_point();
      grid_point_type p;
      int roll;
      p.u_here = random_wind();
      p.u_east = random_wind();
      p.v_here = random_wind();
      p.v_north = random_wind();
      roll = $urandom_range(19);
      if (roll == 0) p.longitude = 17'(46080);
      else if (roll == 1) p.longitude = 17'(-46080);
      else p.longitude = 17'(int'($urandom_range(92160)) - 46080);
      return p;
   endfunction

   // Source gap: mostly none, some short, a few long, with bursts of none.
   function automatic int pick_gap();
      int roll;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         send_burst = $urandom_range(80, 20);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Send one grid point word; valid stays high for a back-to-back follower.
   task automatic send_point(input grid_point_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_u_here <= p.u_here;
      req_u_east <= p.u_east;
      req_v_here <= p.v_here;
      req_v_north <= p.v_north;
      req_longitude <= p.longitude;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_winds.push_back(rotate_to_earth(p));
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_winds.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gwer_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gwer_pkg::WIND_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         gwer_pkg::CSR_CENTER_LONGITUDE: cfg_center = data;
         gwer_pkg::CSR_CONE_FACTOR: cfg_cone = data;
         gwer_pkg::CSR_STAGGERED_MODE: cfg_staggered = data[0];
         gwer_pkg::CSR_MISSING_CHECK_ENABLE: cfg_missing_check = data[0];
         gwer_pkg::CSR_MISSING_CODE: cfg_missing_code = data;
         default: ;
      endcase
   endtask

   // Full register set, written only once the pipeline is empty.
   task automatic set_config(input int center, input int cone, input bit stag,
                             input bit check, input int code);
      wait_drained();
      write_reg(gwer_pkg::CSR_CENTER_LONGITUDE, 16'(center));
      write_reg(gwer_pkg::CSR_CONE_FACTOR, 16'(cone));
      write_reg(gwer_pkg::CSR_STAGGERED_MODE, {15'd0, stag});
      write_reg(gwer_pkg::CSR_MISSING_CHECK_ENABLE, {15'd0, check});
      write_reg(gwer_pkg::CSR_MISSING_CODE, 16'(code));
   endtask

   // Reset registers: zero angle, so only the gain path and rounding act.
   task automatic test_reset_defaults();
      send_point(make_point(32767, 0, 32767, 0, 0));
      send_point(make_point(-32768, 0, -32768, 0, 46080));
      send_point(make_point(32767, -32768, -32768, 32767, -46080));
      send_point(make_point(0, 0, 0, 0, 12345));
      send_point(make_point(-32768, -32768, 1, -1, -1));
   endtask

   // Quarter turns, half turns, wrap limits and saturation at 45 degrees.
   task automatic test_angle_quadrants();
      set_config(0, 32768, 1'b0, 1'b0, -32768);
      send_point(make_point(4660, 0, -2048, 0, 0));
      send_point(make_point(4660, 0, -2048, 0, 11520));
      send_point(make_point(4660, 0, -2048, 0, 11521));
      send_point(make_point(4660, 0, -2048, 0, -11521));
      send_point(make_point(4660, 0, -2048, 0, 23040));
      send_point(make_point(4660, 0, -2048, 0, -23040));
      send_point(make_point(4660, 0, -2048, 0, 23041));
      send_point(make_point(4660, 0, -2048, 0, -23041));
      send_point(make_point(32767, 0, 32767, 0, 5760));
      send_point(make_point(-32768, 0, -32768, 0, -5760));
      set_config(-23040, 32768, 1'b0, 1'b0, -32768);
      send_point(make_point(1000, 0, 3000, 0, 46080));
      set_config(23040, 32768, 1'b0, 1'b0, -32768);
      send_point(make_point(1000, 0, 3000, 0, -46080));
   endtask

   // Missing operands: neighbours count only in staggered mode.
   task automatic test_missing_operands();
      set_config(0, 20000, 1'b0, 1'b1, 32767);
      send_point(make_point(32767, 5, 7, 9, 3000));
      send_point(make_point(5, 5, 32767, 9, 3000));
      send_point(make_point(5, 32767, 7, 32767, 3000));
      set_config(0, 20000, 1'b1, 1'b1, -32768);
      send_point(make_point(5, 7, 9, -32768, 3000));
      send_point(make_point(5, -32768, 9, 11, 3000));
      send_point(make_point(5, 7, 9, 11, 3000));
   endtask

   // Staggered averaging at the extremes and rounding toward minus infinity.
   task automatic test_staggered_average();
      set_config(1000, 16384, 1'b1, 1'b0, -32768);
      send_point(make_point(32767, 32767, 32767, 32767, 0));
      send_point(make_point(-32768, -32768, -32768, -32768, 0));
      send_point(make_point(-1, 0, 1, 0, 0));
      send_point(make_point(-32768, 32767, 32767, -32768, 20000));
   endtask

   // Random register settings, extremes favored, each with a random stream.
   task automatic test_random_phases();
      int center, cone, code;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(3))
            0: center = -23040;
            1: center = 23040;
            2: center = 0;
            default: center = int'($urandom_range(46080)) - 23040;
         endcase
         case ($urandom_range(3))
            0: cone = 0;
            1: cone = 32768;
            default: cone = $urandom_range(32768);
         endcase
         case ($urandom_range(3))
            0: code = -32768;
            1: code = 32767;
            2: code = int'($urandom_range(1023)) - 512;
            default: code = $urandom_range(65535);
         endcase
         set_config(center, cone, 1'($urandom_range(1)), 1'($urandom_range(1)), code);
         repeat (POINTS_PER_PHASE) send_point(random_point());
      end
   endtask

   // Result side: mostly ready, short and long stalls, and stall-free stretches.
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(99);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (free_left > 0) begin
         free_left--;
         rsp_ready <= 1'b1;
      end else if (roll < 3) begin
         free_left = $urandom_range(150, 30);
         rsp_ready <= 1'b1;
      end else if (roll < 10) begin
         stall_left = $urandom_range(3, 0);
         rsp_ready <= 1'b0;
      end else if (roll < 12) begin
         stall_left = $urandom_range(40, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted result word with the oldest prediction.
   always @(posedge clock) begin
      earth_wind_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_winds.size() == 0) begin
            $error("result word with no prediction waiting");
            fail_count++;
         end else begin
            want = expected_winds.pop_front();
            if (rsp_u_earth !== want.u_earth) begin
               $error("u_earth: expected %0d, got %0d", want.u_earth, rsp_u_earth);
               fail_count++;
            end
            if (rsp_v_earth !== want.v_earth) begin
               $error("v_earth: expected %0d, got %0d", want.v_earth, rsp_v_earth);
               fail_count++;
            end
            if (rsp_is_missing !== want.is_missing) begin
               $error("is_missing: expected %0d, got %0d", want.is_missing, rsp_is_missing);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_angle_quadrants();
      test_missing_operands();
      test_staggered_average();
      test_random_phases();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && expected_winds.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/gwer_pkg.sv
rtl/gwer_prep.sv
rtl/gwer_angle.sv
rtl/gwer_cordic_cell.sv
rtl/gwer_finish.sv
rtl/grid_wind_to_earth_rotation.sv
verif/tb_top.sv
